// ===== hdl/skt_pkg.sv =====
// Shared types, constants and helpers for the sorted key table.
package skt_pkg;

	// Table geometry.
	localparam int CAPACITY = 64;
	localparam int KEY_WIDTH = 32;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Fixed port widths.
	localparam int POS_W = 6;
	localparam int CNTO_W = 7;
	localparam int VAL_W = 32;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Operation codes.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_FIND = 2'd1;
	localparam logic [1:0] OP_GET = 2'd2;
	localparam logic [1:0] OP_DELETE = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// Order modes.
	localparam logic [1:0] ORD_APPEND = 2'd0;
	localparam logic [1:0] ORD_ASC = 2'd1;
	localparam logic [1:0] ORD_DESC = 2'd2;

	// Register indexes.
	localparam logic REG_ORDER = 1'b0;
	localparam logic REG_SIGNED = 1'b1;

	// Configuration as seen by the control logic.
	typedef struct packed {
		logic [1:0] order_mode;
		logic compare_signed;
	} skt_cfg_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_PUT,
		S_GET
	} skt_state_t;

	// Map a key so that an unsigned compare gives the selected order.
	function automatic logic [KEY_WIDTH-1:0] rank(input logic [KEY_WIDTH-1:0] k,
			input logic sgn);
		logic [KEY_WIDTH-1:0] flip;
		flip = '0;
		flip[KEY_WIDTH-1] = sgn;
		return k ^ flip;
	endfunction

endpackage

// ===== hdl/skt_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module skt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/skt_cfg.sv =====
// Configuration registers behind the APB-style port.
module skt_cfg import skt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output skt_cfg_t          cfg
);

	logic [1:0] order_mode_q;
	logic       compare_signed_q;
	logic       wr_en;

	// A write completes in the access cycle.
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= ORD_ASC;
			compare_signed_q <= 1'b0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_ORDER: order_mode_q <= pwdata[1:0];
				REG_SIGNED: compare_signed_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register.
	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_ORDER: prdata[1:0] = order_mode_q;
			REG_SIGNED: prdata[0] = compare_signed_q;
			default: prdata = '0;
		endcase
	end

	assign cfg.order_mode = order_mode_q;
	assign cfg.compare_signed = compare_signed_q;

endmodule

// ===== hdl/sorted_key_table_core.sv =====
// Sorted key table: sequencer around one entry RAM, with config registers.
// Get reads the entry at the position; find scans the entries, one RAM read per entry. Ordered
// insert finds the first entry the key sorts before and moves it and later entries up a place,
// then writes the key. Append writes at the tail; delete moves later entries down. One item at
// a time: start is taken while busy is low, the result shows one cycle with done. Full, empty
// and range cases answer from idle. Reset clears the count and config; the RAM is not swept.
module sorted_key_table_core import skt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        mode,
	input  logic [31:0]       key,
	input  logic [POS_W-1:0]  position,
	output logic              done,
	output logic [1:0]        status,
	output logic [POS_W-1:0]  found_index,
	output logic [VAL_W-1:0]  entry_value,
	output logic [CNTO_W-1:0] entry_count
);

	skt_cfg_t cfg;

	skt_state_t state_q, state_d;
	logic [1:0]           op_q, op_d;
	logic [KEY_WIDTH-1:0] key_q, key_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [CNT_W-1:0]     rd_q, rd_d;
	logic [CNT_W-1:0]     left_q, left_d;
	logic [IDX_W-1:0]     at_q, at_d;
	logic                 vld_s1, vld_d;
	logic [IDX_W-1:0]     idx_s1, idx_d;
	logic                 done_q, done_d;
	logic [1:0]           status_q, status_d;
	logic [IDX_W-1:0]     fidx_q, fidx_d;
	logic [KEY_WIDTH-1:0] val_q, val_d;

	logic                 we;
	logic [IDX_W-1:0]     waddr;
	logic [KEY_WIDTH-1:0] wdata;
	logic [IDX_W-1:0]     raddr;
	logic [KEY_WIDTH-1:0] rdata;

	logic                 hit;
	logic                 pos_ok;
	logic                 ordered;
	logic [KEY_WIDTH-1:0] rk, re;

	skt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	skt_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign pready = 1'b1;
	assign busy = (state_q != S_IDLE);

	// Compare the entry coming out of the RAM against the held key.
	assign rk = rank(key_q, cfg.compare_signed);
	assign re = rank(rdata, cfg.compare_signed);
	always_comb begin
		if (op_q == OP_FIND) begin
			hit = (rdata == key_q);
		end else if (cfg.order_mode == ORD_ASC) begin
			hit = (rk < re);
		end else begin
			hit = (rk > re);
		end
	end

	assign ordered = (cfg.order_mode == ORD_ASC) || (cfg.order_mode == ORD_DESC);
	assign pos_ok = (32'(position) < 32'(count_q));

	// Next state, RAM access and result for each step of an operation.
	always_comb begin
		state_d = state_q;
		op_d = op_q;
		key_d = key_q;
		count_d = count_q;
		rd_d = rd_q;
		left_d = left_q;
		at_d = at_q;
		vld_d = 1'b0;
		idx_d = idx_s1;
		done_d = 1'b0;
		status_d = status_q;
		fidx_d = fidx_q;
		val_d = val_q;
		raddr = rd_q[IDX_W-1:0];
		we = 1'b0;
		waddr = at_q;
		wdata = key_q;
		case (state_q)
			S_IDLE: begin
				raddr = IDX_W'(position);
				if (start) begin
					op_d = mode;
					key_d = KEY_WIDTH'(key);
					case (mode)
						OP_INSERT: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								done_d = 1'b1;
								status_d = ST_FULL;
								fidx_d = '0;
								val_d = '0;
							end else if (ordered && count_q != '0) begin
								rd_d = '0;
								state_d = S_SCAN;
							end else begin
								at_d = count_q[IDX_W-1:0];
								state_d = S_PUT;
							end
						end
						OP_FIND: begin
							if (count_q == '0) begin
								done_d = 1'b1;
								status_d = ST_NOT_FOUND;
								fidx_d = '0;
								val_d = '0;
							end else begin
								rd_d = '0;
								state_d = S_SCAN;
							end
						end
						OP_GET: begin
							if (pos_ok) begin
								state_d = S_GET;
							end else begin
								done_d = 1'b1;
								status_d = ST_RANGE;
								fidx_d = '0;
								val_d = '0;
							end
						end
						OP_DELETE: begin
							if (count_q == '0) begin
								done_d = 1'b1;
								status_d = ST_OK;
								fidx_d = '0;
								val_d = '0;
							end else if (!pos_ok) begin
								done_d = 1'b1;
								status_d = ST_RANGE;
								fidx_d = '0;
								val_d = '0;
							end else begin
								rd_d = CNT_W'(position) + CNT_W'(1);
								left_d = count_q - CNT_W'(position) - CNT_W'(1);
								state_d = S_SHIFT;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				// Stream reads over the held entries; data returns in the following cycle.
				if (rd_q < count_q) begin
					rd_d = rd_q + CNT_W'(1);
					vld_d = 1'b1;
					idx_d = rd_q[IDX_W-1:0];
				end
				if (vld_s1 && hit) begin
					vld_d = 1'b0;
					if (op_q == OP_FIND) begin
						done_d = 1'b1;
						status_d = ST_OK;
						fidx_d = idx_s1;
						val_d = rdata;
						state_d = S_IDLE;
					end else begin
						at_d = idx_s1;
						rd_d = count_q - CNT_W'(1);
						left_d = count_q - CNT_W'(idx_s1);
						state_d = S_SHIFT;
					end
				end else if (!vld_s1 && rd_q == count_q) begin
					if (op_q == OP_FIND) begin
						done_d = 1'b1;
						status_d = ST_NOT_FOUND;
						fidx_d = '0;
						val_d = '0;
						state_d = S_IDLE;
					end else begin
						at_d = count_q[IDX_W-1:0];
						state_d = S_PUT;
					end
				end
			end
			S_SHIFT: begin
				// Read one entry and write the previous one a place up or down.
				if (left_q != '0) begin
					vld_d = 1'b1;
					idx_d = rd_q[IDX_W-1:0];
					left_d = left_q - CNT_W'(1);
					rd_d = (op_q == OP_DELETE) ? rd_q + CNT_W'(1) : rd_q - CNT_W'(1);
				end
				if (vld_s1) begin
					we = 1'b1;
					waddr = (op_q == OP_DELETE) ? idx_s1 - IDX_W'(1) : idx_s1 + IDX_W'(1);
					wdata = rdata;
				end
				if (left_q == '0 && !vld_s1) begin
					if (op_q == OP_DELETE) begin
						count_d = count_q - CNT_W'(1);
						done_d = 1'b1;
						status_d = ST_OK;
						fidx_d = '0;
						val_d = '0;
						state_d = S_IDLE;
					end else begin
						state_d = S_PUT;
					end
				end
			end
			S_PUT: begin
				// Write the new key into the opened slot.
				we = 1'b1;
				waddr = at_q;
				wdata = key_q;
				count_d = count_q + CNT_W'(1);
				done_d = 1'b1;
				status_d = ST_OK;
				fidx_d = at_q;
				val_d = '0;
				state_d = S_IDLE;
			end
			S_GET: begin
				done_d = 1'b1;
				status_d = ST_OK;
				fidx_d = '0;
				val_d = rdata;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			vld_s1 <= vld_d;
			done_q <= done_d;
		end
	end

	// Operand, pointer and result registers.
	always_ff @(posedge clk) begin
		op_q <= op_d;
		key_q <= key_d;
		rd_q <= rd_d;
		left_q <= left_d;
		at_q <= at_d;
		idx_s1 <= idx_d;
		status_q <= status_d;
		fidx_q <= fidx_d;
		val_q <= val_d;
	end

	// Result beat.
	assign done = done_q;
	assign status = status_q;
	assign found_index = POS_W'(fidx_q);
	assign entry_value = VAL_W'(val_q);
	assign entry_count = CNTO_W'(count_q);

	// The count never passes the table size.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// The RAM is written only while an operation is in progress.
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q != S_IDLE))
		else $error("RAM write while idle");

	// The count changes only together with a result beat.
	a_count_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> done_q)
		else $error("count changed without a result");

	// Read data is expected only during a scan or a shift.
	a_read_state: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_SCAN || state_q == S_SHIFT))
		else $error("read data in flight outside scan or shift");

	// A key is placed only when the table has room.
	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> (count_q < CNT_W'(CAPACITY)))
		else $error("insert into full table");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the sorted key table core: command driver, result monitor, model.
module testbench;
	import skt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Order mode three has no name in the package; the table treats it as append.
	localparam logic [1:0] ORD_SPARE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int unsigned TAIL_CYCLES = 200;
	localparam int unsigned PHASES = 12;
	localparam int unsigned OPS_PER_PHASE = 156;

	// Operation mixes for the random phases.
	localparam int unsigned MIX_FILL = 0;
	localparam int unsigned MIX_DRAIN = 1;
	localparam int unsigned MIX_EVEN = 2;

	// One queued command: either a table operation or a register write.
	typedef struct {
		logic              is_reg;
		logic [1:0]        mode;
		logic [31:0]       key;
		logic [POS_W-1:0]  position;
		int unsigned       gap;
		logic              reg_sel;
		logic [DATA_W-1:0] reg_value;
	} table_cmd_t;

	typedef struct {
		logic [1:0]        status;
		logic [POS_W-1:0]  found_index;
		logic [VAL_W-1:0]  entry_value;
		logic [CNTO_W-1:0] entry_count;
	} table_result_t;

	typedef enum logic [2:0] {
		DRV_FETCH,
		DRV_GAP,
		DRV_ISSUE,
		DRV_REG_WAIT,
		DRV_REG_SETUP,
		DRV_REG_ACCESS
	} drv_state_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        mode = OP_INSERT;
	logic [31:0]       key = '0;
	logic [POS_W-1:0]  position = '0;
	logic              done;
	logic [1:0]        status;
	logic [POS_W-1:0]  found_index;
	logic [VAL_W-1:0]  entry_value;
	logic [CNTO_W-1:0] entry_count;

	sorted_key_table_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.key         (key),
		.position    (position),
		.done        (done),
		.status      (status),
		.found_index (found_index),
		.entry_value (entry_value),
		.entry_count (entry_count)
	);

	// Commands waiting to be driven and results still owed by the table.
	table_cmd_t    pending_cmds[$];
	table_result_t outcomes_due[$];

	// Shadow copy of the table and its configuration.
	logic [31:0] held_keys [CAPACITY];
	int unsigned held = 0;
	logic [1:0]  ord_sel = ORD_ASC;
	logic        cmp_signed = 1'b0;

	// Stimulus bookkeeping: the count only depends on modes and positions.
	int unsigned gen_count = 0;
	logic [31:0] key_history[$];
	int unsigned gap_style = 1;

	drv_state_t  drv_state = DRV_FETCH;
	int unsigned gap_left = 0;
	int unsigned issued_n = 0;
	int unsigned returned_n = 0;
	int unsigned failures = 0;
	int unsigned cycle_n = 0;
	table_result_t want;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one operation to the shadow table and queue the result it must give.
	task automatic model_table_op(input logic [1:0] op, input logic [31:0] k,
			input logic [POS_W-1:0] pos);
		table_result_t r;
		int unsigned   at;
		int unsigned   i;
		logic          placed;
		logic [31:0]   rk;
		logic [31:0]   re;
		r.status = ST_OK;
		r.found_index = '0;
		r.entry_value = '0;
		placed = 1'b0;
		case (op)
		OP_INSERT: begin
			if (held >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				at = held;
				// Flipping the sign bit turns a signed compare into an unsigned one.
				rk = k ^ {cmp_signed, 31'b0};
				if (ord_sel == ORD_ASC || ord_sel == ORD_DESC) begin
					for (i = 0; i < held; i++) begin
						re = held_keys[i] ^ {cmp_signed, 31'b0};
						if (!placed && ((ord_sel == ORD_ASC) ? (rk < re) : (rk > re))) begin
							at = i;
							placed = 1'b1;
						end
					end
				end
				for (i = held; i > at; i--)
					held_keys[i] = held_keys[i-1];
				held_keys[at] = k;
				held++;
				r.found_index = at[POS_W-1:0];
			end
		end
		OP_FIND: begin
			for (i = 0; i < held; i++) begin
				if (!placed && held_keys[i] == k) begin
					r.found_index = i[POS_W-1:0];
					r.entry_value = held_keys[i];
					placed = 1'b1;
				end
			end
			if (!placed)
				r.status = ST_NOT_FOUND;
		end
		OP_GET: begin
			if (pos < held)
				r.entry_value = held_keys[pos];
			else
				r.status = ST_RANGE;
		end
		default: begin
			// Delete on an empty table reports ok and changes nothing.
			if (held != 0) begin
				if (pos >= held) begin
					r.status = ST_RANGE;
				end else begin
					for (i = 32'(pos); i + 1 < held; i++)
						held_keys[i] = held_keys[i+1];
					held--;
				end
			end
		end
		endcase
		r.entry_count = held[CNTO_W-1:0];
		outcomes_due.push_back(r);
	endtask

	task automatic present_op(input table_cmd_t c);
		mode <= c.mode;
		key <= c.key;
		position <= c.position;
	endtask

	// Command driver: one operation beat at a time, register writes only when idle.
	always @(posedge clk) begin
		if (arst_n) begin
			case (drv_state)
			DRV_FETCH: begin
				if (pending_cmds.size() != 0) begin
					if (pending_cmds[0].is_reg) begin
						drv_state <= DRV_REG_WAIT;
					end else if (pending_cmds[0].gap == 0) begin
						present_op(pending_cmds[0]);
						start <= 1'b1;
						drv_state <= DRV_ISSUE;
					end else begin
						gap_left <= pending_cmds[0].gap - 1;
						drv_state <= DRV_GAP;
					end
				end
			end
			DRV_GAP: begin
				if (gap_left == 0) begin
					present_op(pending_cmds[0]);
					start <= 1'b1;
					drv_state <= DRV_ISSUE;
				end else begin
					gap_left <= gap_left - 1;
				end
			end
			DRV_ISSUE: begin
				if (!busy) begin
					model_table_op(pending_cmds[0].mode, pending_cmds[0].key,
						pending_cmds[0].position);
					pending_cmds.delete(0);
					issued_n <= issued_n + 1;
					// A following operation with no gap keeps start high.
					if (pending_cmds.size() != 0 && !pending_cmds[0].is_reg &&
							pending_cmds[0].gap == 0) begin
						present_op(pending_cmds[0]);
					end else begin
						start <= 1'b0;
						drv_state <= DRV_FETCH;
					end
				end
			end
			DRV_REG_WAIT: begin
				if (issued_n == returned_n && !busy) begin
					psel <= 1'b1;
					pwrite <= 1'b1;
					paddr <= {pending_cmds[0].reg_sel, 2'b00};
					pwdata <= pending_cmds[0].reg_value;
					drv_state <= DRV_REG_SETUP;
				end
			end
			DRV_REG_SETUP: begin
				penable <= 1'b1;
				drv_state <= DRV_REG_ACCESS;
			end
			default: begin
				if (pready) begin
					if (pending_cmds[0].reg_sel == REG_ORDER)
						ord_sel = pending_cmds[0].reg_value[1:0];
					else
						cmp_signed = pending_cmds[0].reg_value[0];
					pending_cmds.delete(0);
					psel <= 1'b0;
					penable <= 1'b0;
					pwrite <= 1'b0;
					drv_state <= DRV_FETCH;
				end
			end
			endcase
		end
	end

	// Result monitor: every done beat is matched against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && done) begin
			returned_n <= returned_n + 1;
			if (outcomes_due.size() == 0) begin
				$error("result beat with no operation outstanding");
				failures++;
			end else begin
				want = outcomes_due.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					failures++;
				end
				if (found_index !== want.found_index) begin
					$error("found_index: expected %0d, got %0d", want.found_index, found_index);
					failures++;
				end
				if (entry_value !== want.entry_value) begin
					$error("entry_value: expected %h, got %h", want.entry_value, entry_value);
					failures++;
				end
				if (entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
					failures++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic queue_op(input logic [1:0] op, input logic [31:0] k,
			input logic [POS_W-1:0] pos);
		table_cmd_t c;
		c.is_reg = 1'b0;
		c.mode = op;
		c.key = k;
		c.position = pos;
		c.reg_sel = REG_ORDER;
		c.reg_value = '0;
		case (gap_style)
		0: c.gap = 0;
		1: c.gap = $urandom_range(0, 17);
		default: c.gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
		endcase
		pending_cmds.push_back(c);
		if (op == OP_INSERT) begin
			if (gen_count < CAPACITY)
				gen_count++;
			key_history.push_back(k);
			if (key_history.size() > 128)
				key_history.delete(0);
		end else if (op == OP_DELETE && gen_count != 0 && pos < gen_count) begin
			gen_count--;
		end
	endtask

	task automatic queue_reg_write(input logic sel, input logic [DATA_W-1:0] value);
		table_cmd_t c;
		c.is_reg = 1'b1;
		c.mode = OP_INSERT;
		c.key = '0;
		c.position = '0;
		c.gap = 0;
		c.reg_sel = sel;
		c.reg_value = value;
		pending_cmds.push_back(c);
	endtask

	// Keys lean toward extremes and small clusters so that ties and sign flips are common.
	function automatic logic [31:0] pick_key(input logic for_find);
		logic [31:0] k;
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (for_find && key_history.size() != 0 && sel < 6) begin
			k = key_history[$urandom_range(0, key_history.size() - 1)];
		end else if (sel < 3) begin
			case ($urandom_range(0, 7))
			0: k = 32'h0000_0000;
			1: k = 32'h0000_0001;
			2: k = 32'h7FFF_FFFF;
			3: k = 32'h8000_0000;
			4: k = 32'h8000_0001;
			5: k = 32'hFFFF_FFFF;
			6: k = 32'hFFFF_FFFE;
			default: k = 32'h7FFF_FFFE;
			endcase
		end else if (sel < 6) begin
			k = $urandom_range(0, 15);
			if ($urandom_range(0, 1) == 1)
				k = ~k;
		end else begin
			k = $urandom();
		end
		return k;
	endfunction

	task automatic queue_random_op(input int unsigned mix);
		int unsigned w;
		int unsigned t_ins;
		int unsigned t_find;
		int unsigned t_get;
		logic [POS_W-1:0] pos;
		case (mix)
		MIX_FILL: begin
			t_ins = 55;
			t_find = 70;
			t_get = 85;
		end
		MIX_DRAIN: begin
			t_ins = 15;
			t_find = 35;
			t_get = 55;
		end
		default: begin
			t_ins = 30;
			t_find = 55;
			t_get = 75;
		end
		endcase
		w = $urandom_range(0, 99);
		// Indexes mostly land on held entries, the rest anywhere in range of the field.
		if (gen_count != 0 && $urandom_range(0, 4) != 0)
			pos = POS_W'($urandom_range(0, gen_count - 1));
		else
			pos = POS_W'($urandom_range(0, 63));
		if (w < t_ins)
			queue_op(OP_INSERT, pick_key(1'b0), POS_W'($urandom_range(0, 63)));
		else if (w < t_find)
			queue_op(OP_FIND, pick_key(1'b1), POS_W'($urandom_range(0, 63)));
		else if (w < t_get)
			queue_op(OP_GET, $urandom(), pos);
		else
			queue_op(OP_DELETE, $urandom(), pos);
	endtask

	initial begin
		int unsigned p;
		int unsigned n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, reset configuration: ascending, unsigned.
		gap_style = 1;
		queue_op(OP_DELETE, 32'h0, 6'd0);
		queue_op(OP_GET, 32'h0, 6'd0);
		queue_op(OP_FIND, 32'h0, 6'd0);
		queue_op(OP_INSERT, 32'h8000_0000, 6'd63);
		queue_op(OP_INSERT, 32'hFFFF_FFFF, 6'd0);
		queue_op(OP_INSERT, 32'h0000_0000, 6'd0);
		queue_op(OP_INSERT, 32'h7FFF_FFFF, 6'd0);
		queue_op(OP_INSERT, 32'h7FFF_FFFF, 6'd0);
		queue_op(OP_INSERT, 32'h0000_0001, 6'd0);
		queue_op(OP_FIND, 32'h7FFF_FFFF, 6'd0);
		queue_op(OP_FIND, 32'h1234_5678, 6'd0);
		queue_op(OP_GET, 32'h0, 6'd0);
		queue_op(OP_GET, 32'h0, 6'd5);
		queue_op(OP_GET, 32'h0, 6'd6);
		queue_op(OP_GET, 32'hFFFF_FFFF, 6'd63);
		queue_op(OP_DELETE, 32'h0, 6'd63);
		queue_op(OP_DELETE, 32'h0, 6'd2);
		queue_op(OP_DELETE, 32'h0, 6'd0);
		queue_op(OP_FIND, 32'hFFFF_FFFF, 6'd0);

		// Signed descending, then order mode three appending at the tail.
		queue_reg_write(REG_SIGNED, 32'h0000_0001);
		queue_reg_write(REG_ORDER, {30'h0, ORD_DESC});
		queue_op(OP_INSERT, 32'h8000_0000, 6'd0);
		queue_op(OP_INSERT, 32'h7FFF_FFFF, 6'd0);
		queue_op(OP_INSERT, 32'hFFFF_FFFF, 6'd0);
		queue_reg_write(REG_ORDER, {30'h0, ORD_SPARE});
		queue_op(OP_INSERT, 32'h0000_0000, 6'd0);
		queue_op(OP_GET, 32'h0, 6'd0);

		// Random phases sweep every order mode under both compare modes.
		for (p = 0; p < PHASES; p++) begin
			queue_reg_write(REG_ORDER, {30'($urandom()), 2'(p % 4)});
			queue_reg_write(REG_SIGNED, {31'($urandom()), 1'((p / 4) % 2)});
			gap_style = $urandom_range(0, 2);
			for (n = 0; n < OPS_PER_PHASE; n++)
				queue_random_op(p % 3);
		end

		while (pending_cmds.size() != 0 || issued_n != returned_n)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
